// ----- rtl/core/can_lvt_pkg.sv -----
// Types, constants and helpers for the CAN last-value table.
// Used by can_frame_last_value_table. Depends on nothing else.
package can_lvt_pkg;

  localparam int unsigned DATA_BYTES = 8;
  localparam logic [3:0]  MAX_LEN    = 4'd8;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte_in0;
    logic [7:0]  byte_in1;
    logic [7:0]  byte_in2;
    logic [7:0]  byte_in3;
    logic [7:0]  byte_in4;
    logic [7:0]  byte_in5;
    logic [7:0]  byte_in6;
    logic [7:0]  byte_in7;
  } can_lvt_in_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  entry_index;
    logic [3:0]  stored_len;
    logic [7:0]  byte_out0;
    logic [7:0]  byte_out1;
    logic [7:0]  byte_out2;
    logic [7:0]  byte_out3;
    logic [7:0]  byte_out4;
    logic [7:0]  byte_out5;
    logic [7:0]  byte_out6;
    logic [7:0]  byte_out7;
    logic        table_full;
  } can_lvt_out_t;

  // One table row apart from its identifier; byte k sits at bits 8k+7..8k.
  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] data;
  } can_lvt_entry_t;

  // Lengths above eight bytes count as eight.
  function automatic logic [3:0] clamp_len(input logic [3:0] len);
    clamp_len = (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [63:0] item_data(input can_lvt_in_t item);
    item_data = {item.byte_in7, item.byte_in6, item.byte_in5, item.byte_in4,
                 item.byte_in3, item.byte_in2, item.byte_in1, item.byte_in0};
  endfunction

  // Replaces the first len bytes of the stored word with the new bytes.
  function automatic logic [63:0] merge_bytes(input logic [63:0] old_data,
                                              input logic [63:0] new_data,
                                              input logic [3:0]  len);
    logic [63:0] res;
    res = old_data;
    for (int k = 0; k < DATA_BYTES; k++) begin
      if (4'(k) < len) begin
        res[8*k +: 8] = new_data[8*k +: 8];
      end
    end
    merge_bytes = res;
  endfunction

  function automatic can_lvt_out_t make_out(input logic        found,
                                            input logic [5:0]  idx,
                                            input logic [3:0]  len,
                                            input logic [63:0] data,
                                            input logic        full);
    can_lvt_out_t o;
    o.found       = found;
    o.entry_index = idx;
    o.stored_len  = len;
    o.byte_out0   = data[7:0];
    o.byte_out1   = data[15:8];
    o.byte_out2   = data[23:16];
    o.byte_out3   = data[31:24];
    o.byte_out4   = data[39:32];
    o.byte_out5   = data[47:40];
    o.byte_out6   = data[55:48];
    o.byte_out7   = data[63:56];
    o.table_full  = full;
    make_out = o;
  endfunction

endpackage

// ----- rtl/core/can_frame_last_value_table.sv -----
// Top level of the CAN last-value table: identifier memory, entry memory and
// the search sequencer. Depends on can_lvt_pkg.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+-----------------------------------
//   input   | start, busy, in_item          | taken when start = 1 and busy = 0
//   result  | out_valid, out_item           | one-cycle strobe, cannot be held
//
// When the identifier is absent the linear search reads every stored entry,
// one identifier a cycle from the identifier memory; a hit costs one more
// read of the entry memory before the result is formed and, for a store,
// before the merge and write-back. A full table holds TABLE_DEPTH = 64 entries.
// Reset clears the sequencer and the fill count only; rows beyond the fill
// count are never used, so no clearing pass is needed. The result is
// signalled for exactly one cycle and the receiver cannot stall it.
module can_frame_last_value_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  can_lvt_pkg::can_lvt_in_t  in_item,
  output logic                      out_valid,
  output can_lvt_pkg::can_lvt_out_t out_item
);
  import can_lvt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  // One bit more than the address so the fill count can reach TABLE_DEPTH.
  localparam int unsigned CW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_MERGE
  } state_t;

  // Storage: one identifier per row, and one length plus eight bytes per row.
  logic [ID_BITS-1:0] id_mem  [TABLE_DEPTH];
  can_lvt_entry_t     ent_mem [TABLE_DEPTH];

  state_t             state_r,    state_nxt;
  logic [CW-1:0]      count_r,    count_nxt;
  logic [CW-1:0]      scan_r,     scan_nxt;
  logic               pend_r,     pend_nxt;
  logic [AW-1:0]      pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]      hit_idx_r,  hit_idx_nxt;
  can_lvt_in_t        item_r,     item_nxt;
  logic               out_valid_r, out_valid_nxt;
  can_lvt_out_t       out_r,      out_nxt;

  logic [ID_BITS-1:0] id_rd_r;
  can_lvt_entry_t     ent_rd_r;

  logic               id_we;
  logic               ent_we;
  logic [AW-1:0]      wr_addr;
  can_lvt_entry_t     ent_wdata;

  logic [ID_BITS-1:0] key;
  logic [3:0]         len_eff;
  logic [63:0]        new_data;
  logic               issue;
  logic               match;
  logic               full;
  logic [63:0]        merged;
  logic [AW+5:0]      hit_idx_ext;
  logic [AW+5:0]      count_ext;

  assign key      = ID_BITS'(item_r.frame_id);
  assign len_eff  = clamp_len(item_r.frame_len);
  assign new_data = item_data(item_r);
  assign issue    = (scan_r < count_r);
  assign match    = pend_r && (id_rd_r == key);
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign merged   = merge_bytes(ent_rd_r.data, new_data, len_eff);

  // The reported index is the low six bits of the entry number.
  assign hit_idx_ext  = {6'd0, hit_idx_r};
  assign count_ext    = {6'd0, count_r[AW-1:0]};

  // Identifier memory: read at the scan pointer every cycle.
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[wr_addr] <= key;
    end
    id_rd_r <= id_mem[scan_r[AW-1:0]];
  end

  // Entry memory: read at the hit row, written on merge or append.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[wr_addr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[hit_idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_idx_nxt   = hit_idx_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    id_we         = 1'b0;
    ent_we        = 1'b0;
    wr_addr       = hit_idx_r;
    ent_wdata     = '{len: ent_rd_r.len, data: merged};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // A read is issued for the next live row while the previous one is
        // compared, so the scan covers one row each cycle.
        pend_nxt     = issue;
        pend_idx_nxt = scan_r[AW-1:0];
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        if (match) begin
          hit_idx_nxt = pend_idx_r;
          state_nxt   = ST_READ;
        end else if (!issue) begin
          // The identifier is absent from every live row.
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (item_r.opcode == OP_LOOKUP) begin
            out_nxt = make_out(1'b0, 6'd0, 4'd0, 64'd0, 1'b0);
          end else if (full) begin
            out_nxt = make_out(1'b0, 6'd0, 4'd0, 64'd0, 1'b1);
          end else begin
            // Append: bytes past the length read as zero in a fresh row.
            id_we     = 1'b1;
            ent_we    = 1'b1;
            wr_addr   = count_r[AW-1:0];
            ent_wdata = '{len: len_eff, data: merge_bytes(64'd0, new_data, len_eff)};
            count_nxt = count_r + CW'(1);
            out_nxt   = make_out(1'b0, count_ext[5:0], len_eff,
                                 merge_bytes(64'd0, new_data, len_eff), 1'b0);
          end
        end
        if (match) begin
          pend_idx_nxt = pend_idx_r;
        end
      end

      ST_READ: begin
        // The entry memory read of the hit row is issued here; its data is registered for ST_MERGE.
        state_nxt = ST_MERGE;
      end

      ST_MERGE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (item_r.opcode == OP_LOOKUP) begin
          out_nxt = make_out(1'b1, hit_idx_ext[5:0], ent_rd_r.len, ent_rd_r.data, 1'b0);
        end else begin
          // A hit keeps the length the row was appended with.
          ent_we  = 1'b1;
          out_nxt = make_out(1'b1, hit_idx_ext[5:0], ent_rd_r.len, merged, 1'b0);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    item_r     <= item_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
